@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define SLSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition is followed by an expression in the next cycle.
`define SLSR_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) cond |=> expr) else $error(msg);

`endif

@@ rtl/core/slsr_pkg.sv @@
package slsr_pkg;

	// Row and column indices are six bits wide; the row slot space is 64.
	localparam int ROW_W = 6;
	localparam int SLOTS = 64;

	// Request actions.
	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_END = 2'd1;
	localparam logic [1:0] ACT_NEW = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_EXTRA = 2'd2;

	// Factor selectors.
	localparam logic FACT_U = 1'b0;
	localparam logic FACT_L = 1'b1;

	typedef struct packed {
		logic             factor;
		logic [ROW_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             last;
		logic [1:0]       status;
	} result_t;

endpackage

@@ rtl/core/slsr_engine.sv @@
module slsr_engine import slsr_pkg::*; #(
	parameter int MAX_ORDER     = 32,
	parameter int L_STORE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ROW_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_action,
	input  logic [ROW_W-1:0] in_row,
	input  logic             out_free,
	output logic             push,
	output result_t          push_res
);

	localparam int PW  = $clog2(L_STORE_DEPTH + 2);
	localparam int AW  = $clog2(L_STORE_DEPTH);
	localparam int CW  = $clog2(MAX_ORDER);
	localparam int CIW = 3 * PW;
	localparam logic [PW-1:0]    DEPTH_P = PW'(L_STORE_DEPTH);
	localparam logic [ROW_W-1:0] TOP_SLOT = ROW_W'(SLOTS - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_QRD   = 4'd1;
	localparam logic [3:0] S_QWAIT = 4'd2;
	localparam logic [3:0] S_CWAIT = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_SWAIT = 4'd5;
	localparam logic [3:0] S_EMIT  = 4'd6;
	localparam logic [3:0] S_CWR   = 4'd7;
	localparam logic [3:0] S_PSEL  = 4'd8;
	localparam logic [3:0] S_PCHK  = 4'd9;
	localparam logic [3:0] S_P1    = 4'd10;
	localparam logic [3:0] S_P1W   = 4'd11;
	localparam logic [3:0] S_P2    = 4'd12;
	localparam logic [3:0] S_P2W   = 4'd13;
	localparam logic [3:0] S_PEND  = 4'd14;
	localparam logic [3:0] S_DONE  = 4'd15;

	logic [3:0]       state_q;
	logic [ROW_W-1:0] order_q, cc_q, head_q, tail_q, idx_q, j_q;
	logic [ROW_W-1:0] a_q, b_q, ri_q;
	logic [SLOTS-1:0] vis_q;
	logic [PW-1:0]    lpos_q, pos_q, p_q, pend_q, lo_q, st_q;
	logic             diag_q, found_q;

	logic [ROW_W-1:0] n_eff;
	logic             accept, cfg_acc;

	// Memories: L row store, node queue (also the prune scratch), column info.
	logic [ROW_W-1:0] l_mem [L_STORE_DEPTH];
	logic [ROW_W-1:0] q_mem [SLOTS];
	logic [CIW-1:0]   c_mem [MAX_ORDER];

	logic             l_we, q_we, c_we;
	logic [AW-1:0]    l_waddr, l_raddr;
	logic [ROW_W-1:0] l_wdata, l_rdata;
	logic [ROW_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
	logic [CW-1:0]    c_waddr, c_raddr;
	logic [CIW-1:0]   c_wdata, c_rdata;

	logic [PW-1:0]    ci_start, ci_fin, ci_pend;
	logic [SLOTS-1:0] mask_le;
	logic             above_none;
	logic             store;
	logic [ROW_W-1:0] ri_next;

	always_ff @(posedge clk) begin
		if (l_we)
			l_mem[l_waddr] <= l_wdata;
		l_rdata <= l_mem[l_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we)
			q_mem[q_waddr] <= q_wdata;
		q_rdata <= q_mem[q_raddr];
	end

	always_ff @(posedge clk) begin
		if (c_we)
			c_mem[c_waddr] <= c_wdata;
		c_rdata <= c_mem[c_raddr];
	end

	// Effective matrix order, kept between one and the supported maximum.
	always_comb begin
		if (order_q == '0)
			n_eff = ROW_W'(1);
		else if ({1'b0, order_q} > (ROW_W+1)'(MAX_ORDER))
			n_eff = ROW_W'(MAX_ORDER);
		else
			n_eff = order_q;
	end

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && out_free && !cfg_valid;
	assign accept    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign ci_start = c_rdata[CIW-1 -: PW];
	assign ci_fin   = c_rdata[2*PW-1 -: PW];
	assign ci_pend  = c_rdata[PW-1:0];

	// Marked rows above the current emission index decide the last flag.
	assign mask_le    = (SLOTS'(2) << idx_q) - SLOTS'(1);
	assign above_none = ((vis_q & ~mask_le) == '0);

	// Scratch read order: low region upward, then high region downward.
	always_comb begin
		if (ri_q < a_q)
			ri_next = (ri_q + ROW_W'(1) == a_q) ? TOP_SLOT : ri_q + ROW_W'(1);
		else
			ri_next = ri_q - ROW_W'(1);
	end

	// Result generation and memory port control.
	always_comb begin
		push     = 1'b0;
		push_res = '{factor: FACT_U, column: cc_q, row: in_row, last: 1'b1,
			status: STAT_OK};
		store    = 1'b0;
		l_we     = 1'b0;
		l_waddr  = pos_q[AW-1:0];
		l_wdata  = cc_q;
		l_raddr  = p_q[AW-1:0];
		q_we     = 1'b0;
		q_waddr  = tail_q;
		q_wdata  = in_row;
		q_raddr  = (state_q == S_P2) ? ri_q : head_q;
		c_we     = 1'b0;
		c_waddr  = cc_q[CW-1:0];
		c_wdata  = {lpos_q, pos_q, pos_q};
		c_raddr  = (state_q == S_QWAIT) ? q_rdata[CW-1:0] : j_q[CW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_action == ACT_ADD || in_action == ACT_END) begin
						if (cc_q >= n_eff) begin
							push = 1'b1;
							push_res.status = STAT_EXTRA;
						end else if (in_action == ACT_ADD) begin
							if (in_row >= n_eff) begin
								push = 1'b1;
								push_res.status = STAT_RANGE;
							end else if (!vis_q[in_row]) begin
								q_we = 1'b1;
							end
						end
					end
				end
			end
			S_SWAIT: begin
				q_wdata = l_rdata;
				q_we    = !vis_q[l_rdata];
			end
			S_EMIT: begin
				if (out_free) begin
					push_res.row  = idx_q;
					push_res.last = 1'b0;
					if (idx_q < cc_q) begin
						push = vis_q[idx_q];
					end else if (idx_q == cc_q) begin
						push = 1'b1;
						if (diag_q) begin
							push_res.factor = FACT_L;
							push_res.last   = above_none;
							store           = 1'b1;
						end
					end else if (idx_q < n_eff) begin
						push            = vis_q[idx_q];
						push_res.factor = FACT_L;
						push_res.last   = above_none;
						store           = vis_q[idx_q];
					end
					l_wdata = idx_q;
					l_we    = store && (pos_q < DEPTH_P);
				end
			end
			S_CWR: begin
				c_we = 1'b1;
			end
			S_P1W: begin
				q_we    = 1'b1;
				q_wdata = l_rdata;
				q_waddr = (l_rdata <= cc_q) ? a_q : b_q;
			end
			S_P2W: begin
				l_we    = 1'b1;
				l_waddr = p_q[AW-1:0];
				l_wdata = q_rdata;
			end
			S_PEND: begin
				c_we    = 1'b1;
				c_waddr = j_q[CW-1:0];
				c_wdata = {st_q, pend_q, lo_q + PW'(a_q)};
			end
			default: begin
			end
		endcase
	end

	// Sequencer: reach, emission with store, then pruning of earlier columns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			order_q <= ROW_W'(32);
			cc_q    <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			vis_q   <= '0;
			lpos_q  <= '0;
			idx_q   <= '0;
			j_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			ri_q    <= '0;
			pos_q   <= '0;
			p_q     <= '0;
			pend_q  <= '0;
			lo_q    <= '0;
			st_q    <= '0;
			diag_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						order_q <= cfg_data;
						cc_q    <= '0;
						head_q  <= '0;
						tail_q  <= '0;
						vis_q   <= '0;
						lpos_q  <= '0;
					end else if (accept) begin
						if (in_action == ACT_NEW) begin
							cc_q   <= '0;
							head_q <= '0;
							tail_q <= '0;
							vis_q  <= '0;
							lpos_q <= '0;
						end else if (in_action == ACT_END) begin
							if (cc_q >= n_eff) begin
								tail_q <= '0;
								vis_q  <= '0;
							end else begin
								head_q  <= '0;
								state_q <= S_QRD;
							end
						end else if (in_action == ACT_ADD) begin
							if (cc_q < n_eff && in_row < n_eff && !vis_q[in_row]) begin
								vis_q[in_row] <= 1'b1;
								tail_q        <= tail_q + ROW_W'(1);
							end
						end
					end
				end
				S_QRD: begin
					if (head_q == tail_q) begin
						idx_q   <= '0;
						diag_q  <= 1'b0;
						pos_q   <= lpos_q;
						state_q <= S_EMIT;
					end else begin
						head_q  <= head_q + ROW_W'(1);
						state_q <= S_QWAIT;
					end
				end
				S_QWAIT: begin
					state_q <= (q_rdata < cc_q) ? S_CWAIT : S_QRD;
				end
				S_CWAIT: begin
					p_q     <= ci_start + PW'(1);
					pend_q  <= ci_pend;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (p_q < pend_q) begin
						p_q     <= p_q + PW'(1);
						state_q <= S_SWAIT;
					end else begin
						state_q <= S_QRD;
					end
				end
				S_SWAIT: begin
					if (!vis_q[l_rdata]) begin
						vis_q[l_rdata] <= 1'b1;
						tail_q         <= tail_q + ROW_W'(1);
					end
					state_q <= S_SCAN;
				end
				S_EMIT: begin
					if (out_free) begin
						if (store && pos_q < DEPTH_P)
							pos_q <= pos_q + PW'(1);
						if (idx_q == cc_q && !diag_q) begin
							diag_q <= 1'b1;
						end else if (idx_q > cc_q && idx_q >= n_eff) begin
							state_q <= S_CWR;
						end else begin
							idx_q <= idx_q + ROW_W'(1);
						end
					end
				end
				S_CWR: begin
					lpos_q  <= pos_q;
					j_q     <= '0;
					state_q <= S_PSEL;
				end
				S_PSEL: begin
					if (j_q == cc_q)
						state_q <= S_DONE;
					else if (vis_q[j_q])
						state_q <= S_PCHK;
					else
						j_q <= j_q + ROW_W'(1);
				end
				S_PCHK: begin
					st_q   <= ci_start;
					lo_q   <= ci_start + PW'(1);
					pend_q <= ci_fin;
					if (ci_pend == ci_fin) begin
						p_q     <= ci_start + PW'(1);
						a_q     <= '0;
						b_q     <= TOP_SLOT;
						found_q <= 1'b0;
						state_q <= S_P1;
					end else begin
						j_q     <= j_q + ROW_W'(1);
						state_q <= S_PSEL;
					end
				end
				S_P1: begin
					if (p_q < pend_q) begin
						p_q     <= p_q + PW'(1);
						state_q <= S_P1W;
					end else if (found_q) begin
						p_q     <= lo_q;
						ri_q    <= (a_q == '0) ? TOP_SLOT : '0;
						state_q <= S_P2;
					end else begin
						j_q     <= j_q + ROW_W'(1);
						state_q <= S_PSEL;
					end
				end
				S_P1W: begin
					if (l_rdata == cc_q)
						found_q <= 1'b1;
					if (l_rdata <= cc_q)
						a_q <= a_q + ROW_W'(1);
					else
						b_q <= b_q - ROW_W'(1);
					state_q <= S_P1;
				end
				S_P2: begin
					if (p_q == pend_q) begin
						state_q <= S_PEND;
					end else begin
						ri_q    <= ri_next;
						state_q <= S_P2W;
					end
				end
				S_P2W: begin
					p_q     <= p_q + PW'(1);
					state_q <= S_P2;
				end
				S_PEND: begin
					j_q     <= j_q + ROW_W'(1);
					state_q <= S_PSEL;
				end
				S_DONE: begin
					vis_q   <= '0;
					head_q  <= '0;
					tail_q  <= '0;
					cc_q    <= cc_q + ROW_W'(1);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/slsr_out.sv @@
module slsr_out import slsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  result_t          push_res,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             factor,
	output logic [ROW_W-1:0] column,
	output logic [ROW_W-1:0] row,
	output logic             last,
	output logic [1:0]       status
);

	logic    valid_q;
	result_t res_q;

	// The slot can take a new result when empty or being drained this cycle.
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= push;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (free && push)
			res_q <= push_res;
	end

	assign out_valid = valid_q;
	assign factor    = res_q.factor;
	assign column    = res_q.column;
	assign row       = res_q.row;
	assign last      = res_q.last;
	assign status    = res_q.status;

endmodule

@@ rtl/core/sparse_lu_symbolic_reach_top.sv @@
// Symbolic sparse LU reach with diagonal pivots and pruned column scans.
// Configuration channel (cfg_valid/cfg_ready, matrix_order) sets the order n
// and starts a new matrix; it is taken only while no column is in work.
// Request channel (in_valid/in_ready, action, row_index): add rows of column
// k, then an end-column request; a new-matrix request clears all columns.
// Result channel (out_valid/out_ready): U(:,k) ascending with the diagonal
// last, then L(:,k) from the diagonal downward; last marks the final result.
// Add and new-matrix requests are handled without leaving the idle state;
// an error result appears in the cycle after its request. End-column work
// is data dependent: a reach over the queued nodes and their scanned L
// entries, emission through one result register, then a pass over the
// entries of each pruned column, all paced by the registered memory reads.
// When the receiver stalls, the sequencer holds and the result stays put.
// Reset clears the counters and marks at once; no memory clearing pass runs.
module sparse_lu_symbolic_reach_top import slsr_pkg::*; #(
	parameter int MAX_ORDER     = 32,
	parameter int L_STORE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ROW_W-1:0] matrix_order,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [ROW_W-1:0] row_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             factor,
	output logic [ROW_W-1:0] column,
	output logic [ROW_W-1:0] row,
	output logic             last,
	output logic [1:0]       status
);

	logic    out_free;
	logic    push;
	result_t push_res;

	// Reach, emission and pruning sequencer with its memories.
	slsr_engine #(
		.MAX_ORDER     (MAX_ORDER),
		.L_STORE_DEPTH (L_STORE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (matrix_order),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_action (action),
		.in_row    (row_index),
		.out_free  (out_free),
		.push      (push),
		.push_res  (push_res)
	);

	// Result register toward the receiver.
	slsr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.factor    (factor),
		.column    (column),
		.row       (row),
		.last      (last),
		.status    (status)
	);

endmodule

@@ rtl/core/slsr_checker.sv @@
`include "assert_macros.svh"

module slsr_checker import slsr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             factor,
	input logic [ROW_W-1:0] column,
	input logic [ROW_W-1:0] row,
	input logic             last,
	input logic [1:0]       status
);

	logic side_ok;

	// U entries lie on or above the diagonal, L entries on or below it.
	assign side_ok = (factor == FACT_U) ? (row <= column) : (row >= column);

	// A stalled result stays offered.
	`SLSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

	// Requests are only taken while configuration could be taken too.
	`SLSR_ASSERT(a_ready_idle, in_ready |-> cfg_ready, "request ready while busy")

	// Every error result closes its request.
	`SLSR_ASSERT(a_err_last, out_valid && status != STAT_OK |-> last, "error without last")

	// Entries stay on their side of the diagonal.
	`SLSR_ASSERT(a_side, out_valid && status == STAT_OK |-> side_ok, "entry off its side")

	// A configuration write and a request are never taken together.
	`SLSR_ASSERT(a_one_take, !(cfg_valid && cfg_ready && in_valid && in_ready), "double take")

endmodule

bind sparse_lu_symbolic_reach_top slsr_checker u_checker (.*);
